FILE: rtl/stfs_pkg.sv
// shared types, constants and the phase-to-coil lookup for the full-step sequencer
`timescale 1ns / 1ps

package stfs_pkg;

  localparam int STEP_W = 32;
  localparam int COIL_W = 4;
  localparam int PHASE_W = 2;
  localparam logic [STEP_W-1:0] STEPS_FOREVER = '1;
  localparam logic [15:0] PHASE_TABLE = 16'h936C;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_DIR     = 2'd2,
    MODE_REVERSE = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [STEP_W-1:0] step_count;
    logic              dir_value;
  } item_t;

  typedef struct packed {
    logic [COIL_W-1:0] coil_pattern;
    logic [STEP_W-1:0] steps_left;
    logic              cur_direction;
    logic              is_running;
  } result_t;

  function automatic logic [COIL_W-1:0] phase_coil(input logic [PHASE_W-1:0] phase);
    phase_coil = PHASE_TABLE[{phase, 2'b00} +: COIL_W];
  endfunction

endpackage

FILE: rtl/stfs_core.sv
// sequencer state registers and the per-request step logic
`timescale 1ns / 1ps

module stfs_core #(
  parameter int PERIOD_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_en,
  input  stfs_pkg::item_t        item,
  input  logic                   cfg_en,
  input  logic [PERIOD_BITS-1:0] cfg_data,
  output stfs_pkg::result_t      result
);

  logic [PERIOD_BITS-1:0]           period;
  logic [PERIOD_BITS-1:0]           elapsed;
  logic [PERIOD_BITS-1:0]           elapsed_next;
  logic [stfs_pkg::STEP_W-1:0]      remaining;
  logic [stfs_pkg::STEP_W-1:0]      remaining_next;
  logic                             dir;
  logic                             dir_next;
  logic                             rev_pending;
  logic                             rev_pending_next;
  logic [stfs_pkg::PHASE_W-1:0]     phase;
  logic [stfs_pkg::PHASE_W-1:0]     phase_next;
  logic [stfs_pkg::COIL_W-1:0]      coil;
  logic [stfs_pkg::COIL_W-1:0]      coil_next;
  logic [PERIOD_BITS-1:0]           elapsed_inc;
  logic                             step_due;
  logic                             running_now;

  assign elapsed_inc = elapsed + PERIOD_BITS'(1);
  assign step_due    = elapsed_inc >= period;
  assign running_now = (remaining != '0) && (period != '0);

  always_comb begin
    elapsed_next     = elapsed;
    remaining_next   = remaining;
    dir_next         = dir;
    rev_pending_next = rev_pending;
    phase_next       = phase;
    coil_next        = coil;
    case (item.mode)
      stfs_pkg::MODE_TICK: begin
        if (running_now) begin
          if (step_due) begin
            elapsed_next     = elapsed_inc - period;
            rev_pending_next = 1'b0;
            dir_next         = dir ^ rev_pending;
            phase_next       = dir_next ? phase - 2'd1 : phase + 2'd1;
            coil_next        = stfs_pkg::phase_coil(phase_next);
            if (remaining != stfs_pkg::STEPS_FOREVER) begin
              remaining_next = remaining - 32'd1;
            end
          end else begin
            elapsed_next = elapsed_inc;
          end
        end else begin
          elapsed_next = '0;
        end
      end
      stfs_pkg::MODE_LOAD:    remaining_next   = item.step_count;
      stfs_pkg::MODE_DIR:     dir_next         = item.dir_value;
      stfs_pkg::MODE_REVERSE: rev_pending_next = 1'b1;
      default:                ;
    endcase
  end

  // result shows the state after this request
  always_comb begin
    result.coil_pattern  = (remaining_next == '0) ? '0 : coil_next;
    result.steps_left    = remaining_next;
    result.cur_direction = dir_next;
    result.is_running    = (remaining_next != '0) && (period != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period      <= '0;
      elapsed     <= '0;
      remaining   <= '0;
      dir         <= 1'b0;
      rev_pending <= 1'b0;
      phase       <= '0;
      coil        <= '0;
    end else if (cfg_en) begin
      period  <= cfg_data;
      elapsed <= '0;
    end else if (item_en) begin
      elapsed     <= elapsed_next;
      remaining   <= remaining_next;
      dir         <= dir_next;
      rev_pending <= rev_pending_next;
      phase       <= phase_next;
      coil        <= coil_next;
    end
  end

endmodule

FILE: rtl/stepper_full_step_sequencer.sv
// Full-step four-coil stepper sequencer, top level.
// Requests arrive on the s_axis channel: tuser carries the mode (tick of one
// microsecond, load step count, set direction, request reversal) and tdata the
// step count and direction value. Every request yields exactly one result on
// m_axis: coil drive pattern, steps left, current direction and running flag,
// all as they stand after that request.
// The step period is written on the cfg channel (always ready); the user must only
// write it while no request is in flight, as the block itself does not enforce
// this; a write also clears the elapsed time. A request passes the input register,
// then the step logic into the result register. Throughput is one request per cycle
// while m_axis does not stall, set by the single state update per request.
// When m_axis stalls, the result register holds and the input register takes
// one more request before s_axis_tready drops.
// Synchronous reset clears the period, count, direction, phase and coils and
// empties both registers.
`timescale 1ns / 1ps

module stepper_full_step_sequencer #(
  parameter int PERIOD_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [39:0]            s_axis_tdata,  // step_count[31:0], dir_value[32], zero pad
  input  logic [1:0]             s_axis_tuser,  // mode[1:0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // coil_pattern[3:0], steps_left[35:4], cur_direction[36], is_running[37], zero pad
  output logic [39:0]            m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [PERIOD_BITS-1:0] cfg_data
);

  logic              in_vld;
  stfs_pkg::item_t   in_item;
  logic              out_vld;
  stfs_pkg::result_t out_res;
  stfs_pkg::result_t core_res;
  logic              out_load;
  logic              proc;

  assign out_load      = !out_vld || m_axis_tready;
  assign proc          = in_vld && out_load;
  assign s_axis_tready = !in_vld || out_load;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.mode       <= stfs_pkg::mode_t'(s_axis_tuser);
      in_item.step_count <= s_axis_tdata[31:0];
      in_item.dir_value  <= s_axis_tdata[32];
    end
  end

  stfs_core #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .item_en  (proc),
    .item     (in_item),
    .cfg_en   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (out_load) begin
      out_vld <= in_vld;
    end
    if (proc) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = {2'b00, out_res.is_running, out_res.cur_direction,
                          out_res.steps_left, out_res.coil_pattern};

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the full-step stepper sequencer
`timescale 1ns / 1ps

module testbench;

  localparam int PERIOD_W = 24;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata = '0;  // step_count[31:0], dir_value[32], zero pad
  logic [1:0]          s_axis_tuser = '0;  // mode[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // coil_pattern[3:0], steps_left[35:4], cur_direction[36], is_running[37], zero pad
  logic [39:0]         m_axis_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data = '0;

  // shadow of the sequencer state
  logic [PERIOD_W-1:0]          period_reg = '0;
  logic [PERIOD_W-1:0]          elapsed_us = '0;
  logic [stfs_pkg::STEP_W-1:0]  steps_reg = '0;
  logic                         dir_bit = 1'b0;
  logic                         rev_pend = 1'b0;
  logic [stfs_pkg::PHASE_W-1:0] phase_q = '0;
  logic [stfs_pkg::COIL_W-1:0]  coil_q = '0;

  stfs_pkg::result_t outputs_due[$];
  int src_idle_pct = 31;
  int sink_idle_pct = 31;
  int mismatches = 0;
  int requests_sent = 0;
  int ticks_sent = 0;
  int steps_taken = 0;
  int period_writes = 0;
  int results_seen = 0;

  stepper_full_step_sequencer #(
    .PERIOD_BITS(PERIOD_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic advance_sequencer(input stfs_pkg::item_t req, output stfs_pkg::result_t res);
    case (req.mode)
      stfs_pkg::MODE_TICK: begin
        if (steps_reg != 0 && period_reg != 0) begin
          elapsed_us = elapsed_us + 1'b1;
          if (elapsed_us >= period_reg) begin
            elapsed_us = elapsed_us - period_reg;
            if (rev_pend) begin
              rev_pend = 1'b0;
              dir_bit = ~dir_bit;
            end
            phase_q = dir_bit ? phase_q - 1'b1 : phase_q + 1'b1;
            case (phase_q)
              2'd0: coil_q = 4'hC;
              2'd1: coil_q = 4'h6;
              2'd2: coil_q = 4'h3;
              default: coil_q = 4'h9;
            endcase
            if (steps_reg != stfs_pkg::STEPS_FOREVER) steps_reg = steps_reg - 1'b1;
            steps_taken++;
          end
        end else begin
          elapsed_us = '0;
        end
      end
      stfs_pkg::MODE_LOAD: steps_reg = req.step_count;
      stfs_pkg::MODE_DIR: dir_bit = req.dir_value;
      default: rev_pend = 1'b1;
    endcase
    res.coil_pattern = (steps_reg == 0) ? '0 : coil_q;
    res.steps_left = steps_reg;
    res.cur_direction = dir_bit;
    res.is_running = (steps_reg != 0) && (period_reg != 0);
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : check_outputs
    stfs_pkg::result_t got;
    stfs_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.coil_pattern = m_axis_tdata[3:0];
      got.steps_left = m_axis_tdata[35:4];
      got.cur_direction = m_axis_tdata[36];
      got.is_running = m_axis_tdata[37];
      results_seen++;
      if (outputs_due.size() == 0) begin
        note_mismatch($sformatf("unexpected result coil=%h steps=%h dir=%b run=%b",
                                got.coil_pattern, got.steps_left, got.cur_direction,
                                got.is_running));
      end else begin
        want = outputs_due.pop_front();
        if (got.coil_pattern !== want.coil_pattern || got.steps_left !== want.steps_left ||
            got.cur_direction !== want.cur_direction || got.is_running !== want.is_running) begin
          note_mismatch($sformatf(
            "result %0d exp coil=%h steps=%h dir=%b run=%b got coil=%h steps=%h dir=%b run=%b",
            results_seen, want.coil_pattern, want.steps_left, want.cur_direction,
            want.is_running, got.coil_pattern, got.steps_left, got.cur_direction,
            got.is_running));
        end
      end
    end
  end

  task automatic send_request(input stfs_pkg::mode_t mode,
                              input logic [stfs_pkg::STEP_W-1:0] count,
                              input logic dir_in);
    stfs_pkg::item_t req;
    stfs_pkg::result_t want;
    req.mode = mode;
    req.step_count = count;
    req.dir_value = dir_in;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= {7'd0, dir_in, count};
    do @(posedge clk); while (!s_axis_tready);
    advance_sequencer(req, want);
    outputs_due.push_back(want);
    requests_sent++;
    if (mode == stfs_pkg::MODE_TICK) ticks_sent++;
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    period_reg = value;
    elapsed_us = '0;
    period_writes++;
  endtask

  task automatic test_idle_defaults();
    // stopped after reset, reversal stays pending
    send_request(stfs_pkg::MODE_TICK, $urandom, 1'($urandom_range(1)));
    send_request(stfs_pkg::MODE_REVERSE, $urandom, 1'($urandom_range(1)));
    send_request(stfs_pkg::MODE_TICK, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic test_stepping_basics();
    write_period(24'd1);
    // coils stay off until the first step
    send_request(stfs_pkg::MODE_LOAD, 32'd3, 1'($urandom_range(1)));
    repeat (4) send_request(stfs_pkg::MODE_TICK, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic test_direction_and_reversal();
    write_period(24'd2);
    send_request(stfs_pkg::MODE_LOAD, 32'd5, 1'b1);
    send_request(stfs_pkg::MODE_DIR, $urandom, 1'b0);
    repeat (2) send_request(stfs_pkg::MODE_TICK, $urandom, 1'b1);
    send_request(stfs_pkg::MODE_REVERSE, $urandom, 1'b0);
    repeat (2) send_request(stfs_pkg::MODE_TICK, $urandom, 1'b0);
    send_request(stfs_pkg::MODE_DIR, $urandom, 1'b1);
  endtask

  task automatic test_infinite_and_stop();
    write_period(PERIOD_MAX);
    send_request(stfs_pkg::MODE_LOAD, stfs_pkg::STEPS_FOREVER, 1'b0);
    repeat (2) send_request(stfs_pkg::MODE_TICK, $urandom, 1'b0);
    write_period(24'd1);
    repeat (2) send_request(stfs_pkg::MODE_TICK, $urandom, 1'b1);
    send_request(stfs_pkg::MODE_LOAD, 32'd0, 1'b1);
    send_request(stfs_pkg::MODE_TICK, $urandom, 1'b0);
    write_period(24'd0);
    send_request(stfs_pkg::MODE_LOAD, 32'h8000_0001, 1'b0);
    send_request(stfs_pkg::MODE_TICK, $urandom, 1'b1);
  endtask

  task automatic test_random_runs();
    logic [PERIOD_W-1:0] periods [8] = '{24'd1, 24'd2, 24'd3, 24'd0, PERIOD_MAX, 24'd4,
                                         24'd1, 24'd6};
    int pick;
    stfs_pkg::mode_t mode;
    logic [stfs_pkg::STEP_W-1:0] count;
    for (int p = 0; p < 8; p++) begin
      write_period(periods[p]);
      // one phase runs back to back with no stalls on either side
      src_idle_pct = (p == 6) ? 0 : 31;
      sink_idle_pct = (p == 6) ? 0 : 31;
      for (int n = 0; n < 85; n++) begin
        pick = $urandom_range(99);
        if (pick < 58) mode = stfs_pkg::MODE_TICK;
        else if (pick < 74) mode = stfs_pkg::MODE_LOAD;
        else if (pick < 87) mode = stfs_pkg::MODE_DIR;
        else mode = stfs_pkg::MODE_REVERSE;
        pick = $urandom_range(9);
        if (pick < 4) count = $urandom_range(1, 12);
        else if (pick == 4) count = '0;
        else if (pick == 5) count = stfs_pkg::STEPS_FOREVER;
        else count = $urandom;
        send_request(mode, count, 1'($urandom_range(1)));
      end
    end
    src_idle_pct = 31;
    sink_idle_pct = 31;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_defaults();
    test_stepping_basics();
    test_direction_and_reversal();
    test_infinite_and_stop();
    test_random_runs();
    s_axis_tvalid <= 1'b0;
    while (outputs_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("sent %0d requests (%0d ticks) over %0d period settings", requests_sent,
             ticks_sent, period_writes);
    $display("motor took %0d steps, %0d results compared", steps_taken, results_seen);
    if (mismatches == 0 && outputs_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", outputs_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
rtl/stfs_pkg.sv
rtl/stfs_core.sv
rtl/stepper_full_step_sequencer.sv
tb/testbench.sv
